// File: hw/rtl/dkst_pkg.sv
// Package for the dense key set table: sizes, request kinds, result codes
// and controller states. No dependencies; every other file imports it.
package dkst_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = 7;
	localparam int KEY_W  = 32;
	localparam int KIND_W = 2;
	localparam int STAT_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED = 3'd0,
		STAT_PRESENT  = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_REMOVED  = 3'd3,
		STAT_NOTFOUND = 3'd4,
		STAT_FOUND    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOVE_RD,
		ST_MOVE_WR,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/dkst_if.sv
// Valid/ready channel interfaces for requests and results of the key set table.
// Depends on dkst_pkg for the field widths.
interface dkst_req_if;
	import dkst_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	modport source (output valid, kind, key, input ready);
	modport sink   (input valid, kind, key, output ready);
endinterface

interface dkst_rsp_if;
	import dkst_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [CNT_W-1:0]  occupancy;
	modport source (output valid, status, occupancy, input ready);
	modport sink   (input valid, status, occupancy, output ready);
endinterface

// File: hw/rtl/dense_key_set_table.sv
// Dense key set table: top level. Uses dkst_pkg and the channels in dkst_if.sv.
// Key zero and kind 3 go straight to ST_DONE; a lookup or insert first scans the count
// held entries (at most 64) at one slot read per cycle, and a remove that hits then
// moves the last entry into the hole through ST_MOVE_RD and ST_MOVE_WR.
// One request at a time; a result word not yet taken holds the next one in ST_DONE.
// Reset clears control, the count and the limit (to 64); slots are never cleared.
module dense_key_set_table (
	input  logic                      clk,
	input  logic                      arst_n,
	dkst_req_if.sink                  req,
	dkst_rsp_if.source                rsp,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);
	import dkst_pkg::*;

	// Register 0 (table_limit) is the only register; paddr[2] set is beyond it.
	localparam logic REG_LIMIT = 1'b0;

	// Controller state and the request being worked on.
	state_t               state_q, state_d;
	kind_t                kind_q;
	logic [KEY_W-1:0]     key_q;
	status_t              stat_q, stat_d;
	logic                 stat_set;

	// Table bookkeeping.
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     limit_q;
	logic [CNT_W-1:0]     eff_lim;
	logic                 room;
	logic [IDX_W-1:0]     last_idx;

	// Scan pointer and the read pipeline of the slot memory.
	logic [CNT_W-1:0]     scan_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic [KEY_W-1:0]     rdata_s1;

	// Slot memory: one write port, one read port, registered read data.
	logic [KEY_W-1:0]     slots [DEPTH];
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [KEY_W-1:0]     mem_wdata;

	// Output register that holds a finished result word until it is taken.
	logic                 out_vld_q;
	status_t              out_stat_q;
	logic [CNT_W-1:0]     out_occ_q;

	logic                 req_fire;
	logic                 needs_scan;
	logic                 issue, hit, miss, decide;
	logic                 do_insert, do_remove;
	logic                 out_load;
	logic                 cfg_write;
	kind_t                req_kind;

	// ------------------------------------------------------------------
	// Configuration port. The limit only changes while the table is empty;
	// a write at any other time is dropped, as is any write beyond register 0.
	// ------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LIMIT);
	assign prdata    = (paddr[2] == REG_LIMIT) ? {{(32-CNT_W){1'b0}}, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= CNT_W'(DEPTH);
		end else if (cfg_write && (count_q == '0)) begin
			limit_q <= pwdata[CNT_W-1:0];
		end
	end

	// A limit of zero acts as one slot, anything above the depth as the depth.
	always_comb begin
		if (limit_q == '0) begin
			eff_lim = CNT_W'(1);
		end else if (limit_q > CNT_W'(DEPTH)) begin
			eff_lim = CNT_W'(DEPTH);
		end else begin
			eff_lim = limit_q;
		end
	end

	assign room     = (count_q < eff_lim);
	assign last_idx = IDX_W'(count_q - CNT_W'(1));

	// ------------------------------------------------------------------
	// Handshakes. A new request is taken whenever the controller is idle,
	// even while the previous result still sits in the output register.
	// ------------------------------------------------------------------
	assign req.ready     = (state_q == ST_IDLE);
	assign req_fire      = req.valid && req.ready;
	assign req_kind      = kind_t'(req.kind);
	assign needs_scan    = (req.key != '0) && (req_kind != KIND_UNUSED);
	assign rsp.valid     = out_vld_q;
	assign rsp.status    = out_stat_q;
	assign rsp.occupancy = out_occ_q;

	// ------------------------------------------------------------------
	// Control outputs. The scan issues one slot read per cycle and compares
	// the registered word that comes back in the next cycle against the key. It ends on the
	// first match, or once every held slot has been read and compared.
	// ------------------------------------------------------------------
	always_comb begin
		issue     = (state_q == ST_SCAN) && (scan_q < count_q);
		hit       = (state_q == ST_SCAN) && rd_vld_s1 && (rdata_s1 == key_q);
		miss      = (state_q == ST_SCAN) && !rd_vld_s1 && !issue;
		decide    = hit || miss;
		do_insert = miss && (kind_q == KIND_INSERT) && room;
		do_remove = (state_q == ST_MOVE_WR);
		out_load  = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

		mem_re    = issue || (state_q == ST_MOVE_RD);
		mem_raddr = (state_q == ST_MOVE_RD) ? last_idx : scan_q[IDX_W-1:0];

		// Insert fills the first empty slot; remove moves the last entry into
		// the hole. The old last slot is left as is: it is never read again
		// before an insert overwrites it.
		mem_we    = do_insert || do_remove;
		mem_waddr = do_remove ? hit_idx_q : count_q[IDX_W-1:0];
		mem_wdata = do_remove ? rdata_s1 : key_q;

		stat_set = 1'b0;
		stat_d   = STAT_NOTFOUND;
		if (req_fire) begin
			// Key zero and the unused kind are settled without touching memory.
			stat_set = 1'b1;
			case (req_kind)
				KIND_INSERT: stat_d = room ? STAT_PRESENT : STAT_FULL;
				KIND_LOOKUP: stat_d = room ? STAT_FOUND : STAT_NOTFOUND;
				default:     stat_d = STAT_NOTFOUND;
			endcase
		end else if (decide) begin
			stat_set = 1'b1;
			case (kind_q)
				KIND_INSERT: begin
					if (hit) begin
						stat_d = STAT_PRESENT;
					end else begin
						stat_d = room ? STAT_INSERTED : STAT_FULL;
					end
				end
				KIND_REMOVE: stat_d = hit ? STAT_REMOVED : STAT_NOTFOUND;
				KIND_LOOKUP: stat_d = hit ? STAT_FOUND : STAT_NOTFOUND;
				default:     stat_d = STAT_NOTFOUND;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Next state.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					state_d = needs_scan ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				if (hit && (kind_q == KIND_REMOVE)) begin
					state_d = ST_MOVE_RD;
				end else if (decide) begin
					state_d = ST_DONE;
				end
			end
			ST_MOVE_RD: state_d = ST_MOVE_WR;
			ST_MOVE_WR: state_d = ST_DONE;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			scan_q    <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (req_fire) begin
				scan_q <= '0;
			end else if (issue) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (do_insert) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_remove) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_q <= req_kind;
			key_q  <= req.key;
		end
		if (stat_set) begin
			stat_q <= stat_d;
		end
		if (hit) begin
			hit_idx_q <= rd_idx_s1;
		end
		rd_idx_s1 <= scan_q[IDX_W-1:0];
		if (out_load) begin
			out_stat_q <= stat_q;
			out_occ_q  <= count_q;
		end
	end

	// Slot memory.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slots[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= slots[mem_raddr];
		end
	end

`ifndef SYNTH
	// The count never passes the effective limit, since the limit only moves
	// while the table is empty.
	a_count_le_limit: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= eff_lim)
		else $error("entry count above the effective limit");

	// The count moves by at most one entry per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))))
		else $error("entry count jumped");

	// A remove only moves an entry when one is held and the hit lies at or below the last one.
	a_move_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOVE_RD) |-> ((count_q != '0) && (hit_idx_q <= last_idx)))
		else $error("remove move outside the held entries");

	// An accepted request always leaves the idle state.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q != ST_IDLE))
		else $error("request accepted but controller stayed idle");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking bench for dense_key_set_table: drives insert, remove and lookup
// requests and checks every result word against a predictor kept in step here.
// Depends on dkst_pkg and the channel interfaces in dkst_if.sv.
module testbench;
	import dkst_pkg::*;

	// The limit register is register 0 of the configuration port.
	localparam logic [2:0] LIMIT_ADDR = 3'd0;

	typedef struct packed {
		kind_t            kind;
		logic [KEY_W-1:0] key;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] occupancy;
	} result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	dkst_req_if req ();
	dkst_rsp_if rsp ();

	dense_key_set_table dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Shadow copy of the table. held_keys[0 .. held_count-1] holds the set,
	// packed from slot 0 upward exactly as the block keeps it.
	logic [KEY_W-1:0] held_keys [DEPTH];
	int               held_count;
	logic [6:0]       limit_reg;

	request_t pending_reqs[$];      // words waiting for the driver
	result_t  expected_results[$];  // predicted result words, oldest first

	// Handshake flags, written at the rising edge and read at the falling one.
	bit req_taken;
	bit rsp_taken;

	bit          quiet_phase;       // when set, neither side idles
	int unsigned send_gap;
	int unsigned recv_stall;

	int fail_count;
	int accepted_count;
	int checked_count;
	int limits_tried;
	int status_seen [6];

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$error("timeout: %0d results still outstanding", expected_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int unsigned draw_gap();
		return quiet_phase ? 0 : $urandom_range(0, 9);
	endfunction

	// A limit of zero behaves as one slot; anything beyond the table depth is
	// clamped to the depth.
	function automatic int eff_limit();
		if (limit_reg == 0) begin
			return 1;
		end
		if (limit_reg > DEPTH) begin
			return DEPTH;
		end
		return int'(limit_reg);
	endfunction

	// Applies one request to the shadow table and returns the result word the
	// block should produce for it.
	function automatic result_t table_apply(kind_t op, logic [KEY_W-1:0] key);
		result_t res;
		int      pos;
		int      lim;
		lim = eff_limit();
		pos = -1;
		res.status = STAT_NOTFOUND;
		// Only held slots are searched, and they are never zero, so key zero
		// never matches here; its special rules are handled per kind below.
		for (int i = 0; i < held_count; i++) begin
			if (pos < 0 && held_keys[i] == key) begin
				pos = i;
			end
		end
		case (op)
			KIND_INSERT: begin
				if (key == '0) begin
					// Zero counts as present while there is room, else as full.
					res.status = (held_count < lim) ? STAT_PRESENT : STAT_FULL;
				end else if (pos >= 0) begin
					res.status = STAT_PRESENT;
				end else if (held_count < lim) begin
					held_keys[held_count] = key;
					held_count++;
					res.status = STAT_INSERTED;
				end else begin
					res.status = STAT_FULL;
				end
			end
			KIND_REMOVE: begin
				// Swap-remove: the last entry fills the hole, the last slot
				// is cleared. Removing zero is simply a miss.
				if (key != '0 && pos >= 0) begin
					held_keys[pos] = held_keys[held_count-1];
					held_keys[held_count-1] = '0;
					held_count--;
					res.status = STAT_REMOVED;
				end
			end
			KIND_LOOKUP: begin
				if (key == '0) begin
					res.status = (held_count < lim) ? STAT_FOUND : STAT_NOTFOUND;
				end else begin
					res.status = (pos >= 0) ? STAT_FOUND : STAT_NOTFOUND;
				end
			end
			default: begin
				// The unused kind changes nothing and reports a miss.
			end
		endcase
		res.occupancy = held_count[CNT_W-1:0];
		return res;
	endfunction

	// Request driver. A word stays on the channel until it is taken; after
	// that the drawn gap, if any, drops valid before the next word goes out.
	always @(negedge clk) begin
		request_t nxt;
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.kind  <= KIND_INSERT;
			req.key   <= '0;
			send_gap = draw_gap();
		end else if (!req.valid || req_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				nxt = pending_reqs.pop_front();
				req.valid <= 1'b1;
				req.kind  <= nxt.kind;
				req.key   <= nxt.key;
				send_gap = draw_gap();
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Result receiver. Before each word it holds ready low for a drawn stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_stall = draw_gap();
		end else begin
			if (rsp_taken) begin
				recv_stall = draw_gap();
			end
			if (recv_stall > 0) begin
				recv_stall--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// Monitor. Accepted requests go through the predictor first, so that the
	// expectation is queued before any result word is compared.
	always @(posedge clk) begin
		result_t want;
		req_taken = arst_n && req.valid === 1'b1 && req.ready === 1'b1;
		rsp_taken = arst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1;
		if (req_taken) begin
			expected_results.push_back(table_apply(kind_t'(req.kind), req.key));
			accepted_count++;
		end
		// A limit write only lands while the table is empty.
		if (arst_n && psel && penable && pwrite && pready === 1'b1
				&& paddr == LIMIT_ADDR && held_count == 0) begin
			limit_reg = pwdata[6:0];
		end
		if (rsp_taken) begin
			if (expected_results.size() == 0) begin
				$error("result word with nothing expected: status %0d occupancy %0d",
					rsp.status, rsp.occupancy);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				checked_count++;
				status_seen[int'(want.status)]++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, got %0d", want.occupancy,
						rsp.occupancy);
					fail_count++;
				end
			end
		end
	end

	task automatic push_req(input kind_t op, input logic [KEY_W-1:0] key);
		request_t r;
		r.kind = op;
		r.key  = key;
		pending_reqs.push_back(r);
	endtask

	// Waits until every queued word has gone out and every result has come.
	// The check runs at the rising edge, where the channel valid has settled
	// since the driver last moved it.
	task automatic wait_drained();
		while (pending_reqs.size() != 0 || req.valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Empties the table by removing every held key, from the front or the
	// back, so the limit can be changed afterward.
	task automatic drain_table(input bit from_back);
		logic [KEY_W-1:0] snap[$];
		wait_drained();
		for (int i = 0; i < held_count; i++) begin
			snap.push_back(held_keys[i]);
		end
		while (snap.size() > 0) begin
			push_req(KIND_REMOVE, from_back ? snap.pop_back() : snap.pop_front());
		end
		wait_drained();
	endtask

	// One random phase. Inserts walk through a key pool a little larger than
	// the limit so the table fills; removes and lookups pick pool keys at
	// random, and a small share of the words is noise: zero keys, the unused
	// kind and keys from outside the pool.
	task automatic run_phase(input int n_items, input int insert_pct);
		logic [KEY_W-1:0] pool[$];
		logic [KEY_W-1:0] k;
		int               pool_n;
		int               next_ins;
		int               r;
		pool_n = eff_limit() + $urandom_range(1, eff_limit() / 2 + 2);
		next_ins = 0;
		for (int i = 0; i < pool_n; i++) begin
			k = $urandom;
			pool.push_back((k == '0) ? 32'h1 : k);
		end
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			k = pool[$urandom_range(0, pool_n - 1)];
			if (r >= 92) begin
				push_req(kind_t'($urandom_range(0, 3)), $urandom_range(0, 1) ? '0 : $urandom);
			end else if (r < insert_pct) begin
				push_req(KIND_INSERT, pool[next_ins % pool_n]);
				next_ins++;
			end else if (r < insert_pct + (92 - insert_pct) / 2) begin
				push_req(KIND_REMOVE, k);
			end else begin
				push_req(KIND_LOOKUP, k);
			end
		end
	endtask

	initial begin
		int limit_plan [10];
		int big;
		limit_plan = '{127, 1, 3, 64, 0, 8, 100, 2, 33, 0};
		limit_plan[9] = $urandom_range(0, 127);

		// Every block input is known from time zero.
		arst_n      = 1'b0;
		req.valid   = 1'b0;
		req.kind    = KIND_INSERT;
		req.key     = '0;
		rsp.ready   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		held_count  = 0;
		limit_reg   = 7'd64;
		quiet_phase = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			held_keys[i] = '0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset limit of 64: key zero on an empty table,
		// the unused kind, a miss on an empty table, extreme keys, a duplicate
		// insert and a remove of the first entry, which pulls the last one in.
		push_req(KIND_LOOKUP, '0);
		push_req(KIND_INSERT, '0);
		push_req(KIND_REMOVE, '0);
		push_req(KIND_UNUSED, 32'hFFFF_FFFF);
		push_req(KIND_REMOVE, 32'h5555_5555);
		push_req(KIND_INSERT, 32'hFFFF_FFFF);
		push_req(KIND_INSERT, 32'h0000_0001);
		push_req(KIND_INSERT, 32'h8000_0000);
		push_req(KIND_INSERT, 32'hFFFF_FFFF);
		push_req(KIND_REMOVE, 32'hFFFF_FFFF);
		push_req(KIND_LOOKUP, 32'h8000_0000);
		push_req(KIND_LOOKUP, 32'h0000_0001);
		push_req(KIND_LOOKUP, 32'hFFFF_FFFF);
		wait_drained();

		// A limit write while entries are held must be ignored: with a limit
		// of 2 the next insert would report full.
		apb_write(LIMIT_ADDR, 32'd2);
		push_req(KIND_INSERT, 32'h7FFF_FFFE);
		drain_table(1'b0);

		// A limit of zero acts as one slot; the upper data bits are junk.
		apb_write(LIMIT_ADDR, 32'hFFFF_FF80);
		limits_tried++;
		push_req(KIND_INSERT, '0);
		push_req(KIND_INSERT, 32'hAAAA_AAAA);
		push_req(KIND_INSERT, 32'h5555_5555);
		push_req(KIND_INSERT, '0);
		push_req(KIND_LOOKUP, '0);
		push_req(KIND_INSERT, 32'hAAAA_AAAA);
		push_req(KIND_REMOVE, 32'hAAAA_AAAA);
		wait_drained();

		// Random phases, each under its own limit. The wait for an empty
		// table before each write also leaves the sender paused until every
		// result has come back.
		for (int p = 0; p < 10; p++) begin
			quiet_phase = (p % 3 == 2);
			apb_write(LIMIT_ADDR, ($urandom & 32'hFFFF_FF80) | limit_plan[p]);
			limits_tried++;
			big = (eff_limit() >= 32);
			run_phase(big ? 60 : 30, big ? 80 : $urandom_range(35, 60));
			wait_drained();
			if ($urandom_range(0, 1)) begin
				apb_write(LIMIT_ADDR, $urandom);
			end
			drain_table(p[0]);
		end

		quiet_phase = 1'b0;
		wait_drained();
		repeat (80) @(negedge clk);

		$display("Covered %0d requests and %0d result words under %0d limit settings:",
			accepted_count, checked_count, limits_tried);
		$display("  %0d stored, %0d already present, %0d full, %0d removed, %0d missed, %0d found.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4], status_seen[5]);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
